### hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int CAPACITY    = 16;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_W  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_LIST       = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_LISTED = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic [1:0]         status;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } cmd_t;

  function automatic logic op_known(input logic [2:0] op);
    return (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK) || (op == OP_POP_FRONT) ||
           (op == OP_POP_BACK) || (op == OP_LIST);
  endfunction

  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] front,
                                                input logic [IDX_W-1:0] offset);
    logic [IDX_W:0] sum;
    sum = {1'b0, front} + {1'b0, offset};
    if (sum >= (IDX_W + 1)'(CAPACITY)) begin
      sum = sum - (IDX_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### hw/rtl/deq_front.sv
`timescale 1ns / 1ps

module deq_front import deq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  assign req_ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      // drop opcodes without meaning
      cmd_valid <= op_known(req_data.opcode);
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd.op    <= req_data.opcode;
      cmd.value <= req_data.value;
    end
  end

endmodule

### hw/rtl/deq_cmdq.sv
`timescale 1ns / 1ps

module deq_cmdq import deq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  cmd_t                  slots [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] fill;
  logic                  push;
  logic                  pop;

  assign wr_ready = fill != CMDQ_CNT_W'(CMDQ_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  function automatic logic [CMDQ_PTR_W-1:0] bump(input logic [CMDQ_PTR_W-1:0] p);
    return (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (rst) fill <= CMDQ_CNT_W'(CMDQ_DEPTH))
    else $error("command queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (wr_ptr == rd_ptr))
    else $error("command queue pointers disagree while empty");
`endif

endmodule

### hw/rtl/deq_back.sv
`timescale 1ns / 1ps

module deq_back import deq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SEND = 2'd2;

  logic [31:0]      mem [CAPACITY];
  logic [31:0]      rd_word;
  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] front_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] walk;
  logic [IDX_W-1:0] walk_next;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             out_free;
  logic             out_load;
  rsp_t             out_next;
  logic             is_full;
  logic             is_empty;
  logic             walk_last;

  assign out_free  = !rsp_valid || rsp_ready;
  assign is_full   = count == CNT_W'(CAPACITY);
  assign is_empty  = count == '0;
  assign walk_last = (CNT_W'(walk) + CNT_W'(1)) == count;

  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    walk_next  = walk;
    wr_en      = 1'b0;
    wr_addr    = ring_pos(front, count[IDX_W-1:0]);
    cmd_ready  = 1'b0;
    out_load   = 1'b0;
    out_next   = '{item_value: '0, status: ST_OK, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          out_load  = 1'b1;
          unique case (cmd.op)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                out_next.status = ST_FULL;
              end else begin
                front_next = (front == '0) ? IDX_W'(CAPACITY - 1) : front - 1'b1;
                wr_addr    = front_next;
                wr_en      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                out_next.status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                out_next.status = ST_EMPTY;
              end else begin
                front_next = ring_pos(front, IDX_W'(1));
                count_next = count - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                out_next.status = ST_EMPTY;
              end else begin
                count_next = count - 1'b1;
              end
            end
            OP_LIST: begin
              if (is_empty) begin
                out_next.status = ST_EMPTY;
              end else begin
                out_load   = 1'b0;
                walk_next  = '0;
                state_next = S_READ;
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_next   = '{item_value: rd_word, status: ST_LISTED, last: walk_last};
          walk_next  = walk + 1'b1;
          state_next = walk_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      walk  <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      walk  <= walk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (state == S_READ) begin
      rd_word <= mem[ring_pos(front, walk)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_data <= out_next;
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (CNT_W'(walk) < count))
    else $error("list walk beyond live elements");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> (count == $past(count)) && (front == $past(front)))
    else $error("queue state changed during list walk");
`endif

endmodule

### hw/rtl/double_ended_queue.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values in a ring of CAPACITY
// entries. Each request beat carries an opcode: push front, push back, pop
// front, pop back or list; unknown opcodes are dropped with no response.
// Pushes and pops answer with one status beat (ok, empty, or full with the
// value dropped). A list answers with one beat per element, front to back,
// last set on the final one; an empty list answers with one empty beat.
// A push or pop is completed when the execute stage takes its command; a list
// takes the command, then does a registered read of the element memory ahead
// of each response beat. A two-entry command queue lets requests keep arriving
// while a list is being walked or a response is stalled.

module double_ended_queue import deq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  deq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  deq_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  deq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import deq_pkg::*;

  localparam int RANDOM_ITEMS = 470;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 80;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  req_t pending[$];
  rsp_t rsp_due[$];

  logic [31:0] ring [CAPACITY];
  int ring_head  = 0;
  int ring_count = 0;

  int gap_left   = 0;
  int req_beats  = 0;
  bit req_calm   = 1'b0;
  int stall_left = 0;
  int rsp_beats  = 0;
  bit rsp_calm   = 1'b0;
  bit held_once  = 1'b0;
  int errors     = 0;
  int idle_count = 0;
  rsp_t want;

  double_ended_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input logic [2:0] op, input logic [31:0] v);
    req_t r;
    r.opcode = op;
    r.value  = v;
    pending.push_back(r);
  endtask

  task automatic deque_predict(input req_t r);
    rsp_t b;
    int i;
    b = '0;
    b.last = 1'b1;
    case (r.opcode)
      OP_PUSH_FRONT: begin
        if (ring_count >= CAPACITY) begin
          b.status = ST_FULL;
        end else begin
          ring_head = (ring_head + CAPACITY - 1) % CAPACITY;
          ring[ring_head] = r.value;
          ring_count++;
          b.status = ST_OK;
        end
        rsp_due.push_back(b);
      end
      OP_PUSH_BACK: begin
        if (ring_count >= CAPACITY) begin
          b.status = ST_FULL;
        end else begin
          ring[(ring_head + ring_count) % CAPACITY] = r.value;
          ring_count++;
          b.status = ST_OK;
        end
        rsp_due.push_back(b);
      end
      OP_POP_FRONT: begin
        if (ring_count == 0) begin
          b.status = ST_EMPTY;
        end else begin
          ring_head = (ring_head + 1) % CAPACITY;
          ring_count--;
          b.status = ST_OK;
        end
        rsp_due.push_back(b);
      end
      OP_POP_BACK: begin
        if (ring_count == 0) begin
          b.status = ST_EMPTY;
        end else begin
          ring_count--;
          b.status = ST_OK;
        end
        rsp_due.push_back(b);
      end
      OP_LIST: begin
        if (ring_count == 0) begin
          b.status = ST_EMPTY;
          rsp_due.push_back(b);
        end else begin
          for (i = 0; i < ring_count; i++) begin
            b.item_value = ring[(ring_head + i) % CAPACITY];
            b.status     = ST_LISTED;
            b.last       = (i == ring_count - 1);
            rsp_due.push_back(b);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_valid && req_ready) begin
        deque_predict(req_data);
        req_beats++;
        if (req_beats % 50 == 0) begin
          req_calm = ($urandom_range(0, 3) == 0);
        end
        gap_left = req_calm ? 0 : pick_gap();
      end
      if (!req_valid || req_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          req_data  <= pending.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_beats++;
        if (rsp_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat value=%0d status=%0d last=%0b", $time,
                   $signed(rsp_data.item_value), rsp_data.status, rsp_data.last);
        end else begin
          want = rsp_due.pop_front();
          if (rsp_data.item_value !== want.item_value || rsp_data.status !== want.status ||
              rsp_data.last !== want.last) begin
            errors++;
            $display("%0t: expected %0d st=%0d last=%0b, got %0d st=%0d last=%0b",
                     $time, $signed(want.item_value), want.status, want.last,
                     $signed(rsp_data.item_value), rsp_data.status, rsp_data.last);
          end
        end
        if (rsp_beats % 50 == 0) begin
          rsp_calm = ($urandom_range(0, 3) == 0);
        end
        stall_left = rsp_calm ? 0 : pick_gap();
      end
      // hold off once for a long stretch so the request side backs up
      if (!held_once && rsp_beats >= 100) begin
        held_once  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_count = 0;
    end else begin
      idle_count++;
      if (idle_count >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int seg_len;
    int mode;
    int r;
    int k;

    add_req(OP_LIST, 32'h0);
    add_req(OP_POP_FRONT, 32'hFFFF_FFFF);
    add_req(OP_POP_BACK, 32'h1234_5678);
    add_req(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    add_req(OP_PUSH_BACK, 32'h8000_0000);
    add_req(OP_PUSH_FRONT, 32'h0000_0000);
    add_req(OP_PUSH_BACK, 32'hFFFF_FFFF);
    add_req(OP_PUSH_BACK, 32'h5555_5555);
    add_req(OP_PUSH_FRONT, 32'hAAAA_AAAA);
    add_req(OP_LIST, 32'h0);
    add_req(OP_POP_FRONT, 32'h0);
    add_req(OP_POP_BACK, 32'h0);
    add_req(OP_LIST, 32'hFFFF_FFFF);
    for (k = int'(OP_UNUSED_LO); k <= int'(OP_UNUSED_HI); k++) begin
      add_req(k[2:0], 32'hFFFF_FFFF);
    end
    add_req(OP_LIST, 32'h0);
    add_req(OP_POP_BACK, 32'h0);
    add_req(OP_POP_FRONT, 32'h0);
    add_req(OP_POP_BACK, 32'h0);
    add_req(OP_POP_FRONT, 32'h0);
    add_req(OP_POP_BACK, 32'h0);
    add_req(OP_LIST, 32'h0);

    // segments that mostly fill, mostly drain, or mix, so full and empty both recur
    n = 0;
    while (n < RANDOM_ITEMS) begin
      seg_len = $urandom_range(8, 34);
      mode    = $urandom_range(0, 2);
      for (k = 0; k < seg_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          add_req(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom);
        end else begin
          n++;
          if (r < 13) begin
            add_req(OP_LIST, $urandom);
          end else if ((mode == 0 && r < 88) || (mode == 1 && r < 28) ||
                       (mode == 2 && r < 56)) begin
            add_req($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_value());
          end else begin
            add_req($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, $urandom);
          end
        end
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || req_valid || rsp_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
